// ===== hdl/swtb_pkg.sv =====
// Shared types and constants for the software timer bank.
package swtb_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int CNT_W     = 32;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int STEP_W    = 8;
  localparam int REQ_W     = 3;
  localparam int STAT_W    = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK     = 3'd0,
    REQ_START    = 3'd1,
    REQ_RESTART  = 3'd2,
    REQ_SET_TIME = 3'd3,
    REQ_STOP     = 3'd4,
    REQ_RELEASE  = 3'd5,
    REQ_READ     = 3'd6,
    REQ_UNKNOWN  = 3'd7
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_FULL       = 2'd1,
    STAT_NOT_IN_USE = 2'd2
  } stat_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_RD,
    S_EXEC
  } fsm_e;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [3:0]        slot_index;
    logic [31:0]       period_in;
    logic [STEP_W-1:0] tick_step;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [3:0]        slot_out;
    logic [31:0]       count_value;
    logic [31:0]       period_value;
    logic              done_value;
    logic [15:0]       expired_mask;
  } res_t;

  typedef struct packed {
    logic              cnt_we;
    logic              per_we;
    logic [SLOT_W-1:0] addr;
    logic [CNT_W-1:0]  cnt_data;
    logic [CNT_W-1:0]  per_data;
  } mem_wr_t;

endpackage

// ===== hdl/swtb_slot_mem.sv =====
// Count and period storage for all timer slots, one write and one registered read port.
module swtb_slot_mem (
  input  logic                          clk_i,
  input  swtb_pkg::mem_wr_t             wr_i,
  input  logic [swtb_pkg::SLOT_W-1:0]   rd_addr_i,
  output logic [swtb_pkg::CNT_W-1:0]    rd_cnt_o,
  output logic [swtb_pkg::CNT_W-1:0]    rd_per_o
);

  logic [swtb_pkg::CNT_W-1:0] cnt_mem [swtb_pkg::NUM_SLOTS];
  logic [swtb_pkg::CNT_W-1:0] per_mem [swtb_pkg::NUM_SLOTS];
  logic [swtb_pkg::CNT_W-1:0] rd_cnt_q;
  logic [swtb_pkg::CNT_W-1:0] rd_per_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.cnt_we) begin
      cnt_mem[wr_i.addr] <= wr_i.cnt_data;
    end
    if (wr_i.per_we) begin
      per_mem[wr_i.addr] <= wr_i.per_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_cnt_q <= cnt_mem[rd_addr_i];
    rd_per_q <= per_mem[rd_addr_i];
  end

  assign rd_cnt_o = rd_cnt_q;
  assign rd_per_o = rd_per_q;

endmodule

// ===== hdl/software_timer_bank_core.sv =====
// Top level of the software timer bank: request sequencer, tick datapath and slot flags.
//
// Usage: drive req_i and raise start; the transaction is taken at a rising edge
// where start is high and busy is low. busy stays high until the result is out.
// Each transaction yields exactly one result on res_o, shown for one cycle with
// res_valid_o high. The receiver cannot stall, so the result must be taken then.
// Sequencing:
//   tick: the slot memory is walked one slot per cycle through its single read
//   port, read, saturating add, then compare-subtract and write back; the result
//   strobes as the last slot is written back, and the next transaction can be
//   taken at the edge that ends the strobe.
//   all other requests: memory read, then update; the result strobes with the
//   update, and the next request can be taken at the edge that ends the strobe.
// A new transaction may be accepted in the cycle the previous result is shown.
// Reset clears the used marks, done flags and sequencer; counts and periods
// are written when a slot is claimed and need no reset.
module software_timer_bank_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  swtb_pkg::req_t req_i,
  output logic           busy,
  output logic           res_valid_o,
  output swtb_pkg::res_t res_o
);

  localparam int NS = swtb_pkg::NUM_SLOTS;
  localparam int CW = swtb_pkg::CNT_W;
  localparam int SW = swtb_pkg::SLOT_W;
  localparam logic [SW-1:0] LAST_SLOT = SW'(NS - 1);

  swtb_pkg::fsm_e state_q, state_d;
  swtb_pkg::req_t req_q, req_d;
  swtb_pkg::res_t res_q, res_d;
  logic           res_valid_q, res_valid_d;
  logic [NS-1:0]  used_q, used_d;
  logic [NS-1:0]  done_q, done_d;
  logic [15:0]    mask_q, mask_d;

  logic [SW-1:0]  ptr_q, ptr_d;
  logic           issue_q, issue_d;
  logic           s1_vld_q, s1_vld_d;
  logic [SW-1:0]  s1_slot_q, s1_slot_d;
  logic           s2_vld_q, s2_vld_d;
  logic [SW-1:0]  s2_slot_q, s2_slot_d;
  logic [CW-1:0]  sum_q, sum_d;
  logic [CW-1:0]  per2_q, per2_d;

  swtb_pkg::mem_wr_t mem_wr;
  logic [SW-1:0]     rd_addr;
  logic [CW-1:0]     rd_cnt;
  logic [CW-1:0]     rd_per;

  logic [CW:0]    sum_ext;
  logic [CW:0]    diff_ext;
  logic           expire;
  logic           active;
  logic [SW-1:0]  free_idx;
  logic           free_found;
  logic [SW-1:0]  idx;

  swtb_slot_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .rd_addr_i (rd_addr),
    .rd_cnt_o  (rd_cnt),
    .rd_per_o  (rd_per)
  );

  assign idx      = req_q.slot_index[SW-1:0];
  assign rd_addr  = (state_q == swtb_pkg::S_TICK) ? ptr_q : idx;
  assign sum_ext  = (CW+1)'(rd_cnt) + (CW+1)'(req_q.tick_step);
  assign diff_ext = {1'b0, sum_q} - {1'b0, per2_q};
  assign expire   = ~diff_ext[CW];
  assign active   = used_q[s2_slot_q] & ~done_q[s2_slot_q];

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx   = SW'(i);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    used_d      = used_q;
    done_d      = done_q;
    mask_d      = mask_q;
    ptr_d       = ptr_q;
    issue_d     = issue_q;
    s1_vld_d    = 1'b0;
    s1_slot_d   = ptr_q;
    s2_vld_d    = s1_vld_q;
    s2_slot_d   = s1_slot_q;
    sum_d       = sum_ext[CW] ? '1 : sum_ext[CW-1:0];
    per2_d      = rd_per;
    mem_wr      = '0;

    unique case (state_q)
      swtb_pkg::S_IDLE: begin
        if (start) begin
          req_d = req_i;
          if (req_i.req_type == swtb_pkg::REQ_TICK) begin
            state_d = swtb_pkg::S_TICK;
            ptr_d   = '0;
            issue_d = 1'b1;
            mask_d  = '0;
          end else begin
            state_d = swtb_pkg::S_RD;
          end
        end
      end

      swtb_pkg::S_TICK: begin
        s1_vld_d = issue_q;
        if (issue_q) begin
          ptr_d = ptr_q + 1'b1;
          if (ptr_q == LAST_SLOT) begin
            issue_d = 1'b0;
          end
        end
        if (s2_vld_q) begin
          if (active) begin
            mem_wr.cnt_we = 1'b1;
            mem_wr.addr   = s2_slot_q;
            mem_wr.cnt_data = expire ? diff_ext[CW-1:0] : sum_q;
            if (expire) begin
              done_d[s2_slot_q] = 1'b1;
              mask_d[s2_slot_q] = 1'b1;
            end
          end
          if (s2_slot_q == LAST_SLOT) begin
            res_d              = '0;
            res_d.status       = swtb_pkg::STAT_OK;
            res_d.expired_mask = mask_d;
            res_valid_d        = 1'b1;
            state_d            = swtb_pkg::S_IDLE;
          end
        end
      end

      swtb_pkg::S_RD: begin
        state_d = swtb_pkg::S_EXEC;
      end

      swtb_pkg::S_EXEC: begin
        res_d       = '0;
        res_valid_d = 1'b1;
        state_d     = swtb_pkg::S_IDLE;
        if (req_q.req_type == swtb_pkg::REQ_START) begin
          if (free_found) begin
            used_d[free_idx] = 1'b1;
            done_d[free_idx] = 1'b0;
            mem_wr.cnt_we    = 1'b1;
            mem_wr.per_we    = 1'b1;
            mem_wr.addr      = free_idx;
            mem_wr.cnt_data  = '0;
            mem_wr.per_data  = CW'(req_q.period_in);
            res_d.status       = swtb_pkg::STAT_OK;
            res_d.slot_out     = 4'(free_idx);
            res_d.period_value = 32'(mem_wr.per_data);
          end else begin
            res_d.status = swtb_pkg::STAT_FULL;
          end
        end else if (req_q.req_type == swtb_pkg::REQ_TICK ||
                     req_q.req_type == swtb_pkg::REQ_UNKNOWN) begin
          res_d.status = swtb_pkg::STAT_OK;
        end else if (!used_q[idx]) begin
          res_d.status   = swtb_pkg::STAT_NOT_IN_USE;
          res_d.slot_out = req_q.slot_index;
        end else begin
          res_d.status       = swtb_pkg::STAT_OK;
          res_d.slot_out     = req_q.slot_index;
          res_d.count_value  = 32'(rd_cnt);
          res_d.period_value = 32'(rd_per);
          res_d.done_value   = done_q[idx];
          mem_wr.addr        = idx;
          unique case (req_q.req_type)
            swtb_pkg::REQ_RESTART: begin
              mem_wr.cnt_we     = 1'b1;
              done_d[idx]       = 1'b0;
              res_d.count_value = '0;
              res_d.done_value  = 1'b0;
            end
            swtb_pkg::REQ_SET_TIME: begin
              mem_wr.cnt_we      = 1'b1;
              mem_wr.per_we      = 1'b1;
              mem_wr.per_data    = CW'(req_q.period_in);
              done_d[idx]        = 1'b0;
              res_d.count_value  = '0;
              res_d.period_value = 32'(mem_wr.per_data);
              res_d.done_value   = 1'b0;
            end
            swtb_pkg::REQ_STOP: begin
              done_d[idx]      = 1'b1;
              res_d.done_value = 1'b1;
            end
            swtb_pkg::REQ_RELEASE: begin
              used_d[idx]      = 1'b0;
              done_d[idx]      = 1'b0;
              res_d.done_value = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      default: begin
        state_d = swtb_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swtb_pkg::S_IDLE;
      res_valid_q <= 1'b0;
      used_q      <= '0;
      done_q      <= '0;
      issue_q     <= 1'b0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      used_q      <= used_d;
      done_q      <= done_d;
      issue_q     <= issue_d;
      s1_vld_q    <= s1_vld_d;
      s2_vld_q    <= s2_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    res_q     <= res_d;
    mask_q    <= mask_d;
    ptr_q     <= ptr_d;
    s1_slot_q <= s1_slot_d;
    s2_slot_q <= s2_slot_d;
    sum_q     <= sum_d;
    per2_q    <= per2_d;
  end

  assign busy        = (state_q != swtb_pkg::S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_full_means_all_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.status == swtb_pkg::STAT_FULL |-> &used_q)
    else $error("table full reported while a slot is free");

  a_expired_are_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_q.expired_mask & ~done_q) == '0)
    else $error("expired slot not marked done");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |=> !res_valid_q)
    else $error("more than one result strobe per transaction");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !res_valid_q)
    else $error("accepted transaction did not raise busy");

endmodule
